// ===== hw/rtl/bed_roughness_theta_unit_assert.svh =====
// assertion macros for the bed roughness theta unit
// expects clk and rst_n in the scope where a macro is used
`ifndef BED_ROUGHNESS_THETA_UNIT_ASSERT_SVH
`define BED_ROUGHNESS_THETA_UNIT_ASSERT_SVH

// condition must hold on every clock while out of reset
`define BRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BRT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/brt_pkg.sv =====
// shared widths, constants and types for the bed roughness theta unit
// no dependencies
`default_nettype none

package brt_pkg;

  localparam int TH_W    = 21;   // thickness, 8 fraction bits
  localparam int COEF_W  = 48;   // coefficients, 8 fraction bits
  localparam int THETA_W = 17;   // theta, Q1.16
  localparam int DIV_W   = 121;  // divisor and remainder width
  localparam int Q_W     = 32;   // quotient bits, 1/omega in Q0.32

  localparam logic [THETA_W-1:0] THETA_ONE  = 17'h10000;
  localparam logic [THETA_W-1:0] THETA_ZERO = 17'h00000;
  localparam logic [TH_W-1:0]    THR_RESET  = 21'd25600;

  // per-transaction override flags carried alongside the divider
  typedef struct packed {
    logic force_en;   // result does not come from the divider
    logic force_one;  // forced value is 1.0, otherwise 0
  } brt_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brt_mulh.sv =====
// one horner step: y = a * h + addend, two register stages
// depends on brt_pkg
`default_nettype none

module brt_mulh #(
  parameter int AW = 58,
  parameter int OW = AW + 23
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [AW-1:0]         a,
  input  logic [brt_pkg::TH_W-1:0]     h,
  input  logic signed [OW-1:0]         addend,
  output logic signed [OW-1:0]         y,
  output logic [brt_pkg::TH_W-1:0]     h_out
);

  localparam int NL = (AW + 31) / 32;
  localparam int XA = 32 * NL;
  localparam int GW = XA + 32;
  localparam int XW = (GW > OW) ? GW : OW;

  logic signed [XA-1:0] a_x;
  logic [GW-1:0] ev_nxt, od_nxt;
  logic [GW-1:0] ev_r, od_r;
  logic signed [OW-1:0] add_r;
  logic [brt_pkg::TH_W-1:0] ha_r, hb_r;
  logic signed [XW-1:0] sum;
  logic signed [OW-1:0] y_r;

  assign a_x = XA'(a);

  // limb products; limbs of one parity never overlap, so packing is wiring
  always_comb begin
    logic [52:0] pu;
    logic signed [53:0] ps;
    logic [63:0] pk;
    ev_nxt = '0;
    od_nxt = '0;
    for (int k = 0; k < NL; k++) begin
      if (k == NL - 1) begin
        ps = $signed(a_x[32*k +: 32]) * $signed({1'b0, h});
        pk = 64'(ps);
        pu = '0;
      end else begin
        pu = a_x[32*k +: 32] * h;
        pk = {11'b0, pu};
        ps = '0;
      end
      if ((k % 2) == 0) begin
        ev_nxt[32*k +: 64] = pk;
      end else begin
        od_nxt[32*k +: 64] = pk;
      end
    end
  end

  assign sum = XW'($signed(ev_r)) + XW'($signed(od_r)) + XW'(add_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ev_r  <= ev_nxt;
      od_r  <= od_nxt;
      add_r <= addend;
      ha_r  <= h;
      y_r   <= $signed(sum[OW-1:0]);
      hb_r  <= ha_r;
    end
  end

  assign y     = y_r;
  assign h_out = hb_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bed_roughness_theta_unit.sv =====
// bed roughness theta unit: theta = omega^-3, omega = 1 + sum Ck/H^k, clamped to [0,1]
// out_valid follows the input transaction through 44 register stages
// throughput one transaction per cycle while the output is not stalled, every stage including the divider is pipelined
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// synchronous active-low reset clears all valid bits and sets threshold to 100.0 m
// depends on brt_pkg, brt_mulh and bed_roughness_theta_unit_assert.svh
`default_nettype none

module bed_roughness_theta_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [brt_pkg::TH_W-1:0]           cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [brt_pkg::TH_W-1:0]           in_thickness,
  input  logic signed [brt_pkg::COEF_W-1:0]  in_coef_two,
  input  logic signed [brt_pkg::COEF_W-1:0]  in_coef_three,
  input  logic signed [brt_pkg::COEF_W-1:0]  in_coef_four,
  input  logic signed [brt_pkg::COEF_W-1:0]  in_coef_five,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [brt_pkg::THETA_W-1:0]        out_theta
);

  // stage map
  //  1     capture, h^2
  //  2     a0 = h^2 + 2^8 c2
  //  3..8  three horner steps in h (numerator) alongside h^3, h^4, h^5
  //  9     classify: thin ice, negative, zero or small omega
  //  10..41 restoring divider, one quotient bit per stage
  //  42    q^2, 43 q^3, 44 output register
  localparam int ST_HOR  = 8;
  localparam int ST_CLS  = 9;
  localparam int ST_DIV0 = ST_CLS + 1;
  localparam int ST_DIVN = ST_CLS + brt_pkg::Q_W;
  localparam int ST_SQ   = ST_DIVN + 1;
  localparam int ST_CUBE = ST_SQ + 1;
  localparam int ST_OUT  = ST_CUBE + 1;

  localparam int A0_W = 58;
  localparam int A1_W = A0_W + 23;
  localparam int A2_W = A1_W + 23;
  localparam int N_W  = A2_W + 23;
  localparam int B0_W = 43;
  localparam int B1_W = B0_W + 23;
  localparam int B2_W = B1_W + 23;
  localparam int B3_W = B2_W + 23;

  localparam int TW = brt_pkg::TH_W;
  localparam int CW = brt_pkg::COEF_W;
  localparam int DW = brt_pkg::DIV_W;
  localparam int QW = brt_pkg::Q_W;

  // global advance: the pipe moves unless a finished result is held back
  logic en;
  logic [ST_OUT:1] vld_r;
  logic [TW-1:0] thr_r;

  assign en       = !(vld_r[ST_OUT] && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= brt_pkg::THR_RESET;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (en) begin
        vld_r <= {vld_r[ST_OUT-1:1], in_valid};
      end
    end
  end

  // stage 1 and 2: capture, square, first horner term
  logic [TW-1:0]         h1_r, h2_r;
  logic [2*TW-1:0]       hsq_r, b0_r;
  logic signed [CW-1:0]  c2_r, c3_1_r, c3_2_r;
  logic signed [CW-1:0]  c4_r [1:4];
  logic signed [CW-1:0]  c5_r [1:6];
  logic                  thin_r [1:ST_HOR];
  logic signed [A0_W-1:0] a0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r      <= in_thickness;
      hsq_r     <= {{TW{1'b0}}, in_thickness} * {{TW{1'b0}}, in_thickness};
      c2_r      <= in_coef_two;
      c3_1_r    <= in_coef_three;
      c4_r[1]   <= in_coef_four;
      c5_r[1]   <= in_coef_five;
      thin_r[1] <= (in_thickness <= thr_r);

      h2_r   <= h1_r;
      b0_r   <= hsq_r;
      a0_r   <= $signed({16'b0, hsq_r}) + $signed({{2{c2_r[CW-1]}}, c2_r, 8'h00});
      c3_2_r <= c3_1_r;
      for (int i = 2; i <= 4; i++) begin
        c4_r[i] <= c4_r[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
        c5_r[i] <= c5_r[i-1];
      end
      for (int i = 2; i <= ST_HOR; i++) begin
        thin_r[i] <= thin_r[i-1];
      end
    end
  end

  // numerator chain: (((h^2 + 2^8 c2) h + 2^16 c3) h + 2^24 c4) h + 2^32 c5
  logic signed [A1_W-1:0] a1;
  logic signed [A2_W-1:0] a2;
  logic signed [N_W-1:0]  num;
  logic [TW-1:0] ha1, ha2, ha3;

  brt_mulh #(.AW(A0_W), .OW(A1_W)) u_num1 (
    .clk(clk), .en(en), .a(a0_r), .h(h2_r),
    .addend({{17{c3_2_r[CW-1]}}, c3_2_r, 16'h0000}),
    .y(a1), .h_out(ha1)
  );
  brt_mulh #(.AW(A1_W), .OW(A2_W)) u_num2 (
    .clk(clk), .en(en), .a(a1), .h(ha1),
    .addend({{32{c4_r[4][CW-1]}}, c4_r[4], 24'h000000}),
    .y(a2), .h_out(ha2)
  );
  brt_mulh #(.AW(A2_W), .OW(N_W)) u_num3 (
    .clk(clk), .en(en), .a(a2), .h(ha2),
    .addend({{47{c5_r[6][CW-1]}}, c5_r[6], 32'h00000000}),
    .y(num), .h_out(ha3)
  );

  // denominator chain h^3, h^4, h^5 on the same step unit with no addend
  logic signed [B1_W-1:0] b1;
  logic signed [B2_W-1:0] b2;
  logic signed [B3_W-1:0] h5;
  logic [TW-1:0] hb1, hb2, hb3;

  brt_mulh #(.AW(B0_W), .OW(B1_W)) u_pow1 (
    .clk(clk), .en(en), .a($signed({1'b0, b0_r})), .h(h2_r),
    .addend('0), .y(b1), .h_out(hb1)
  );
  brt_mulh #(.AW(B1_W), .OW(B2_W)) u_pow2 (
    .clk(clk), .en(en), .a(b1), .h(hb1),
    .addend('0), .y(b2), .h_out(hb2)
  );
  brt_mulh #(.AW(B2_W), .OW(B3_W)) u_pow3 (
    .clk(clk), .en(en), .a(b2), .h(hb2),
    .addend('0), .y(h5), .h_out(hb3)
  );

  // stage 9: classify; omega > 1 exactly when num > h^5
  logic [DW-1:0] h5_x;
  logic          cls_neg, cls_zero, cls_small;
  brt_pkg::brt_side_t cls_side;

  assign h5_x      = DW'($unsigned(h5));
  assign cls_neg   = num[N_W-1];
  assign cls_zero  = (num == '0);
  assign cls_small = !cls_neg && (num[DW-1:0] <= h5_x);

  always_comb begin
    cls_side.force_en  = thin_r[ST_HOR] || cls_neg || cls_zero || cls_small;
    cls_side.force_one = thin_r[ST_HOR] || !cls_neg;
  end

  brt_pkg::brt_side_t side_r [ST_CLS:ST_CUBE];
  logic [DW-1:0] rem_r [ST_CLS:ST_DIVN];
  logic [DW-1:0] d_r   [ST_CLS:ST_DIVN];
  logic [QW-1:0] q_r   [ST_CLS:ST_DIVN];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[ST_CLS] <= cls_side;
      rem_r[ST_CLS]  <= h5_x;
      d_r[ST_CLS]    <= num[DW-1:0];
      q_r[ST_CLS]    <= '0;
      for (int i = ST_CLS + 1; i <= ST_CUBE; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // restoring division of 2^32 h^5 by num; remainder stays below the divisor
  for (genvar i = ST_DIV0; i <= ST_DIVN; i++) begin : g_div
    logic [DW:0] sh;
    logic [DW:0] df;

    assign sh = {rem_r[i-1], 1'b0};
    assign df = sh - {1'b0, d_r[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= df[DW] ? sh[DW-1:0] : df[DW-1:0];
        d_r[i]   <= d_r[i-1];
        q_r[i]   <= {q_r[i-1][QW-2:0], !df[DW]};
      end
    end
  end

  // stages 42 to 44: t = q^2 >> 32, theta = t q >> 48, then override
  logic [2*QW-1:0] sq_prod, cube_prod;
  logic [QW-1:0]   t_r, q_sq_r;
  logic [15:0]     frac_r;
  logic [brt_pkg::THETA_W-1:0] theta_r;

  assign sq_prod   = {{QW{1'b0}}, q_r[ST_DIVN]} * {{QW{1'b0}}, q_r[ST_DIVN]};
  assign cube_prod = {{QW{1'b0}}, t_r} * {{QW{1'b0}}, q_sq_r};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= sq_prod[2*QW-1:QW];
      q_sq_r <= q_r[ST_DIVN];
      frac_r <= cube_prod[2*QW-1:2*QW-16];
      if (side_r[ST_CUBE].force_en) begin
        theta_r <= side_r[ST_CUBE].force_one ? brt_pkg::THETA_ONE : brt_pkg::THETA_ZERO;
      end else begin
        theta_r <= {1'b0, frac_r};
      end
    end
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_theta = theta_r;

  // live divider transactions at entry and exit
  logic div_in_live, div_out_live;

  assign div_in_live  = vld_r[ST_CLS] && !side_r[ST_CLS].force_en;
  assign div_out_live = vld_r[ST_DIVN] && !side_r[ST_DIVN].force_en;

`include "bed_roughness_theta_unit_assert.svh"

  // theta never exceeds 1.0
  `BRT_ASSERT_IMPLY(a_theta_range, out_valid, out_theta <= brt_pkg::THETA_ONE, "theta above one")
  // a divided transaction starts with h^5 strictly below the divisor
  `BRT_ASSERT_IMPLY(a_div_entry, div_in_live, rem_r[ST_CLS] < d_r[ST_CLS], "bad divider entry")
  // the divider keeps its remainder below the divisor to the last stage
  `BRT_ASSERT_IMPLY(a_div_exit, div_out_live, rem_r[ST_DIVN] < d_r[ST_DIVN], "bad remainder")
  // both thickness copies stay in step through the horner steps
  `BRT_ASSERT_IMPLY(a_h_align, vld_r[ST_HOR], ha3 == hb3, "thickness copies out of step")

endmodule

`default_nettype wire
